FILE: rtl/mwups_pkg.sv
// Shared types and codes for the max-weight uplink poll scheduler.
// No dependencies; used by the scan unit and the top level.
package mwups_pkg;

   localparam int ADDR_W   = 32;
   localparam int Q16_W    = 16;
   localparam int WEIGHT_W = 33;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [KIND_W-1:0] KIND_REGISTER = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REPORT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DATA     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POLL     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BEGIN    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_TARGET = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_VIOLATION = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_REALTIME   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WEIGHT = 1'd1;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [Q16_W-1:0]  reliability;
   } static_entry_type;

   typedef struct packed {
      logic signed [Q16_W-1:0] queue;
      logic [Q16_W-1:0]        expected_id;
      logic [Q16_W-1:0]        received;
   } dyn_entry_type;

   typedef struct packed {
      logic                       done;
      logic signed [WEIGHT_W-1:0] weight;
   } scan_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MODIFY,
      ST_SCAN,
      ST_FETCH,
      ST_CLEAR,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/max_weight_uplink_poll_scheduler.sv
// Max-weight uplink poll scheduler: client table in two RAMs, a sequencer and
// a pipelined weight scan. Depends on mwups_pkg, mwups_ram and mwups_argmax.
//
// The request channel (req_) carries one command beat: register a client, a
// queue report, a data arrival, a poll or the start of an interval. Every
// command returns exactly one beat on the response channel (rsp_). The csr_
// channel writes realtime_mode (index 0) and min_weight (index 1) and is
// always ready; the user must write it only while the block is idle; the
// block itself does not enforce this. One command is in flight at a time.
// rsp_valid rises after the DISPATCH and RESP states for register, unknown
// and plain begin-interval commands, with MODIFY between them for reports
// and data arrivals, CLEAR for a begin-interval in realtime mode and SCAN and
// FETCH for a poll (no FETCH when it finds no target): the scan reads one
// table entry per cycle through the single read port of the table RAMs, then
// a multiply and a compare stage. req_ready returns in the cycle after the
// response is loaded. A finished response waits in an output register, so
// the next command is accepted while the receiver stalls; its own response
// is held back until the previous beat has gone. Reset empties the table,
// drops the target and restores realtime_mode 0 and min_weight 1; table RAM
// contents are kept.
module max_weight_uplink_poll_scheduler #(
   parameter int MAX_CLIENTS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [mwups_pkg::KIND_W-1:0]            req_kind,
   input  logic [mwups_pkg::ADDR_W-1:0]            req_client_addr,
   input  logic [mwups_pkg::Q16_W-1:0]             req_reliability,
   input  logic [mwups_pkg::Q16_W-1:0]             req_count,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_target_valid,
   output logic [mwups_pkg::INDEX_W-1:0]           rsp_target_index,
   output logic [mwups_pkg::ADDR_W-1:0]            rsp_target_addr,
   output logic [mwups_pkg::Q16_W-1:0]             rsp_expected_id,
   output logic signed [mwups_pkg::Q16_W-1:0]      rsp_queue_len,
   output logic [mwups_pkg::STATUS_W-1:0]          rsp_status,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mwups_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mwups_pkg::ADDR_W-1:0]            csr_data
);

   localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int CNT_W = $clog2(MAX_CLIENTS + 1);

   typedef struct packed {
      logic                                 target_valid;
      logic [mwups_pkg::INDEX_W-1:0]        index;
      logic [mwups_pkg::ADDR_W-1:0]         addr;
      logic [mwups_pkg::Q16_W-1:0]          expected_id;
      logic signed [mwups_pkg::Q16_W-1:0]   queue;
      logic [mwups_pkg::STATUS_W-1:0]       status;
   } result_type;

   function automatic result_type res_none(input logic [mwups_pkg::STATUS_W-1:0] st);
      result_type r;
      r        = '0;
      r.status = st;
      return r;
   endfunction

   function automatic result_type res_entry(
      input logic                               tv,
      input logic [IDX_W-1:0]                   idx,
      input logic [mwups_pkg::ADDR_W-1:0]       addr,
      input logic [mwups_pkg::Q16_W-1:0]        eid,
      input logic signed [mwups_pkg::Q16_W-1:0] q,
      input logic [mwups_pkg::STATUS_W-1:0]     st
   );
      result_type                r;
      logic [IDX_W+4:0]          wide;
      wide           = {5'b0, idx};
      r.target_valid = tv;
      r.index        = wide[4:0];
      r.addr         = addr;
      r.expected_id  = eid;
      r.queue        = q;
      r.status       = st;
      return r;
   endfunction

   function automatic logic signed [15:0] sat_count(input logic [15:0] c);
      return c[15] ? 16'sh7fff : $signed(c);
   endfunction

   function automatic logic signed [15:0] sat_diff(input logic [15:0] c,
                                                   input logic [15:0] r);
      logic signed [16:0] d;
      d = $signed({1'b0, c}) - $signed({1'b0, r});
      if (d > 17'sd32767) begin
         return 16'sh7fff;
      end else if (d < -17'sd32768) begin
         return 16'sh8000;
      end
      return d[15:0];
   endfunction

   function automatic logic signed [15:0] sat_dec(input logic signed [15:0] q);
      return (q == 16'sh8000) ? q : (q - 16'sd1);
   endfunction

   mwups_pkg::state_type              state_ff, state_in;
   logic [mwups_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [mwups_pkg::ADDR_W-1:0]      addr_ff, addr_in;
   logic [mwups_pkg::Q16_W-1:0]       rel_ff, rel_in;
   logic [mwups_pkg::Q16_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [IDX_W-1:0]                  target_ff, target_in;
   logic                              tset_ff, tset_in;
   logic                              realtime_ff, realtime_in;
   logic [mwups_pkg::ADDR_W-1:0]      minw_ff, minw_in;
   logic [IDX_W-1:0]                  sweep_ff, sweep_in;
   result_type                        res_ff, res_in;
   result_type                        rsp_ff, rsp_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic                              st_we, dy_we;
   logic [IDX_W-1:0]                  wr_addr, rd_addr;
   mwups_pkg::static_entry_type       st_wdata, st_rdata;
   mwups_pkg::dyn_entry_type          dy_wdata, dy_rdata;
   logic                              scan_start;
   logic [IDX_W-1:0]                  scan_rd_addr, scan_best;
   mwups_pkg::scan_status_type        scan_stat;
   logic signed [mwups_pkg::Q16_W-1:0] nq;
   logic [mwups_pkg::Q16_W-1:0]       neid;

   mwups_ram #(
      .WIDTH($bits(mwups_pkg::static_entry_type)),
      .DEPTH(MAX_CLIENTS)
   ) u_static_ram (
      .clock  (clock),
      .wr_en  (st_we),
      .wr_addr(wr_addr),
      .wr_data(st_wdata),
      .rd_addr(rd_addr),
      .rd_data(st_rdata)
   );

   mwups_ram #(
      .WIDTH($bits(mwups_pkg::dyn_entry_type)),
      .DEPTH(MAX_CLIENTS)
   ) u_dyn_ram (
      .clock  (clock),
      .wr_en  (dy_we),
      .wr_addr(wr_addr),
      .wr_data(dy_wdata),
      .rd_addr(rd_addr),
      .rd_data(dy_rdata)
   );

   mwups_argmax #(
      .MAX_CLIENTS(MAX_CLIENTS)
   ) u_argmax (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .count      (count_ff),
      .rd_addr    (scan_rd_addr),
      .rd_static  (st_rdata),
      .rd_dyn     (dy_rdata),
      .best_index (scan_best),
      .scan_status(scan_stat)
   );

   always_comb begin
      realtime_in = realtime_ff;
      minw_in     = minw_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mwups_pkg::CSR_REALTIME:   realtime_in = csr_data[0];
            mwups_pkg::CSR_MIN_WEIGHT: minw_in     = csr_data;
            default:                   minw_in     = minw_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      rel_in       = rel_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      target_in    = target_ff;
      tset_in      = tset_ff;
      sweep_in     = sweep_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      st_we        = 1'b0;
      dy_we        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      st_wdata     = '{addr: addr_ff, reliability: rel_ff};
      dy_wdata     = '0;
      rd_addr      = target_ff;
      scan_start   = 1'b0;
      nq           = '0;
      neid         = '0;

      unique case (state_ff)
         mwups_pkg::ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               addr_in  = req_client_addr;
               rel_in   = req_reliability;
               cnt_in   = req_count;
               state_in = mwups_pkg::ST_DISPATCH;
            end
         end
         mwups_pkg::ST_DISPATCH: begin
            state_in = mwups_pkg::ST_RESP;
            unique case (kind_ff) inside
               mwups_pkg::KIND_REGISTER: begin
                  if (count_ff == CNT_W'(MAX_CLIENTS)) begin
                     res_in = res_none(mwups_pkg::STATUS_FULL);
                  end else begin
                     nq       = sat_count(cnt_ff);
                     st_we    = 1'b1;
                     dy_we    = 1'b1;
                     dy_wdata = '{queue: nq, expected_id: '0, received: '0};
                     count_in = count_ff + 1'b1;
                     res_in   = res_entry(1'b0, count_ff[IDX_W-1:0], addr_ff, '0, nq,
                                          mwups_pkg::STATUS_OK);
                  end
               end
               mwups_pkg::KIND_REPORT, mwups_pkg::KIND_DATA: begin
                  if (!tset_ff || (CNT_W'(target_ff) >= count_ff)) begin
                     res_in = res_none(mwups_pkg::STATUS_NO_TARGET);
                  end else begin
                     state_in = mwups_pkg::ST_MODIFY;
                  end
               end
               mwups_pkg::KIND_POLL: begin
                  if (count_ff == '0) begin
                     tset_in = 1'b0;
                     res_in  = res_none(mwups_pkg::STATUS_NO_TARGET);
                  end else begin
                     scan_start = 1'b1;
                     state_in   = mwups_pkg::ST_SCAN;
                  end
               end
               mwups_pkg::KIND_BEGIN: begin
                  tset_in = 1'b0;
                  res_in  = res_none(mwups_pkg::STATUS_OK);
                  if (realtime_ff && (count_ff != '0)) begin
                     sweep_in = '0;
                     state_in = mwups_pkg::ST_CLEAR;
                  end
               end
               default: begin
                  res_in = res_none(mwups_pkg::STATUS_OK);
               end
            endcase
         end
         mwups_pkg::ST_MODIFY: begin
            state_in = mwups_pkg::ST_RESP;
            wr_addr  = target_ff;
            if (kind_ff == mwups_pkg::KIND_REPORT) begin
               if (realtime_ff && (dy_rdata.received != '0)) begin
                  res_in = res_entry(1'b0, target_ff, st_rdata.addr, dy_rdata.expected_id,
                                     dy_rdata.queue, mwups_pkg::STATUS_VIOLATION);
               end else begin
                  nq       = sat_diff(cnt_ff, dy_rdata.received);
                  neid     = ((dy_rdata.expected_id == '0) && (nq > 16'sd0))
                           ? 16'd1 : dy_rdata.expected_id;
                  dy_we    = 1'b1;
                  dy_wdata = '{queue: nq, expected_id: neid, received: dy_rdata.received};
                  res_in   = res_entry(1'b0, target_ff, st_rdata.addr, neid, nq,
                                       mwups_pkg::STATUS_OK);
               end
            end else begin
               nq       = sat_dec(dy_rdata.queue);
               neid     = dy_rdata.expected_id + 1'b1;
               dy_we    = 1'b1;
               dy_wdata = '{queue: nq, expected_id: neid,
                            received: dy_rdata.received + 1'b1};
               res_in   = res_entry(1'b0, target_ff, st_rdata.addr, neid, nq,
                                    mwups_pkg::STATUS_OK);
            end
         end
         mwups_pkg::ST_SCAN: begin
            rd_addr = scan_stat.done ? scan_best : scan_rd_addr;
            if (scan_stat.done) begin
               if (scan_stat.weight < $signed({1'b0, minw_ff})) begin
                  tset_in  = 1'b0;
                  res_in   = res_none(mwups_pkg::STATUS_NO_TARGET);
                  state_in = mwups_pkg::ST_RESP;
               end else begin
                  tset_in   = 1'b1;
                  target_in = scan_best;
                  state_in  = mwups_pkg::ST_FETCH;
               end
            end
         end
         mwups_pkg::ST_FETCH: begin
            res_in   = res_entry(1'b1, target_ff, st_rdata.addr, dy_rdata.expected_id,
                                 dy_rdata.queue, mwups_pkg::STATUS_OK);
            state_in = mwups_pkg::ST_RESP;
         end
         mwups_pkg::ST_CLEAR: begin
            dy_we    = 1'b1;
            wr_addr  = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if ((CNT_W'(sweep_ff) + 1'b1) == count_ff) begin
               state_in = mwups_pkg::ST_RESP;
            end
         end
         mwups_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = mwups_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mwups_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwups_pkg::ST_IDLE;
         count_ff     <= '0;
         target_ff    <= '0;
         tset_ff      <= 1'b0;
         realtime_ff  <= 1'b0;
         minw_ff      <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         target_ff    <= target_in;
         tset_ff      <= tset_in;
         realtime_ff  <= realtime_in;
         minw_ff      <= minw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      rel_ff   <= rel_in;
      cnt_ff   <= cnt_in;
      sweep_ff <= sweep_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready        = (state_ff == mwups_pkg::ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_valid = rsp_ff.target_valid;
   assign rsp_target_index = rsp_ff.index;
   assign rsp_target_addr  = rsp_ff.addr;
   assign rsp_expected_id  = rsp_ff.expected_id;
   assign rsp_queue_len    = rsp_ff.queue;
   assign rsp_status       = rsp_ff.status;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CLIENTS))
      else $error("client count beyond table depth");

   a_target_in_table: assert property (@(posedge clock) disable iff (reset)
      tset_ff |-> (CNT_W'(target_ff) < count_ff))
      else $error("target points past the last registered client");

   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_stat.done |-> (state_ff == mwups_pkg::ST_SCAN))
      else $error("scan finished outside a poll");

   a_table_grows_by_one: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + 1'b1))
      else $error("client count moved by other than one");
`endif

endmodule

FILE: rtl/mwups_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module mwups_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mwups_argmax.sv
// Pipelined weight scan: reads one table entry per cycle, multiplies queue by
// reliability and keeps the first maximum. Depends on mwups_pkg.
module mwups_argmax #(
   parameter int MAX_CLIENTS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [$clog2(MAX_CLIENTS+1)-1:0]         count,
   output logic [((MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1)-1:0] rd_addr,
   input  mwups_pkg::static_entry_type              rd_static,
   input  mwups_pkg::dyn_entry_type                 rd_dyn,
   output logic [((MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1)-1:0] best_index,
   output mwups_pkg::scan_status_type               scan_status
);

   localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int CNT_W = $clog2(MAX_CLIENTS + 1);

   logic                                  running_ff, running_in;
   logic [IDX_W-1:0]                      issue_ff, issue_in;
   logic                                  p1_valid_ff, p1_valid_in;
   logic                                  p1_last_ff, p1_last_in;
   logic [IDX_W-1:0]                      p1_idx_ff, p1_idx_in;
   logic                                  p2_valid_ff, p2_valid_in;
   logic                                  p2_last_ff, p2_last_in;
   logic [IDX_W-1:0]                      p2_idx_ff, p2_idx_in;
   logic signed [mwups_pkg::WEIGHT_W-1:0] p2_weight_ff, p2_weight_in;
   logic                                  have_ff, have_in;
   logic [IDX_W-1:0]                      best_idx_ff, best_idx_in;
   logic signed [mwups_pkg::WEIGHT_W-1:0] best_weight_ff, best_weight_in;
   logic                                  done_ff, done_in;
   logic                                  last_issue;

   always_comb begin
      last_issue     = (CNT_W'(issue_ff) + 1'b1) == count;
      running_in     = running_ff;
      issue_in       = issue_ff;
      have_in        = have_ff;
      best_idx_in    = best_idx_ff;
      best_weight_in = best_weight_ff;

      if (start) begin
         running_in = 1'b1;
         issue_in   = '0;
         have_in    = 1'b0;
      end else if (running_ff) begin
         issue_in = issue_ff + 1'b1;
         if (last_issue) begin
            running_in = 1'b0;
         end
      end

      p1_valid_in = running_ff;
      p1_last_in  = running_ff && last_issue;
      p1_idx_in   = issue_ff;

      p2_valid_in  = p1_valid_ff;
      p2_last_in   = p1_last_ff;
      p2_idx_in    = p1_idx_ff;
      p2_weight_in = mwups_pkg::WEIGHT_W'($signed(rd_dyn.queue))
                   * mwups_pkg::WEIGHT_W'($signed({1'b0, rd_static.reliability}));

      if (p2_valid_ff && (!have_ff || (p2_weight_ff > best_weight_ff))) begin
         have_in        = 1'b1;
         best_idx_in    = p2_idx_ff;
         best_weight_in = p2_weight_ff;
      end

      done_in = p2_valid_ff && p2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         have_ff     <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         running_ff  <= running_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
         have_ff     <= have_in;
         done_ff     <= done_in;
      end
      issue_ff       <= issue_in;
      p1_last_ff     <= p1_last_in;
      p1_idx_ff      <= p1_idx_in;
      p2_last_ff     <= p2_last_in;
      p2_idx_ff      <= p2_idx_in;
      p2_weight_ff   <= p2_weight_in;
      best_idx_ff    <= best_idx_in;
      best_weight_ff <= best_weight_in;
   end

   assign rd_addr            = issue_ff;
   assign best_index         = best_idx_ff;
   assign scan_status.done   = done_ff;
   assign scan_status.weight = best_weight_ff;

endmodule

FILE: bench/tb_max_weight_uplink_poll_scheduler.sv
// Self-checking bench for the max-weight uplink poll scheduler: directed and random
// command beats are scored, field by field, against an in-bench model of the client table.
// Depends on mwups_pkg and the scheduler RTL only.
module tb_max_weight_uplink_poll_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 6;
   localparam int TABLE_DEPTH   = 32;
   localparam int SETTLE_CYCLES = 48;
   localparam int QUIET_LIMIT   = 2000;
   localparam int QUEUE_MAX     = 32767;
   localparam int QUEUE_MIN     = -32768;
   localparam logic [31:0] PEAK_WEIGHT = 32'd2147385345;
   localparam logic [mwups_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [mwups_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

   typedef struct {
      logic [mwups_pkg::KIND_W-1:0] kind;
      logic [mwups_pkg::ADDR_W-1:0] addr;
      logic [mwups_pkg::Q16_W-1:0]  reliability;
      logic [mwups_pkg::Q16_W-1:0]  count;
   } sched_cmd_type;

   typedef struct {
      logic                               target_valid;
      logic [mwups_pkg::INDEX_W-1:0]      target_index;
      logic [mwups_pkg::ADDR_W-1:0]       target_addr;
      logic [mwups_pkg::Q16_W-1:0]        expected_id;
      logic signed [mwups_pkg::Q16_W-1:0] queue_len;
      logic [mwups_pkg::STATUS_W-1:0]     status;
   } poll_reply_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic [mwups_pkg::KIND_W-1:0]          req_kind = '0;
   logic [mwups_pkg::ADDR_W-1:0]          req_client_addr = '0;
   logic [mwups_pkg::Q16_W-1:0]           req_reliability = '0;
   logic [mwups_pkg::Q16_W-1:0]           req_count = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic                                  rsp_target_valid;
   logic [mwups_pkg::INDEX_W-1:0]         rsp_target_index;
   logic [mwups_pkg::ADDR_W-1:0]          rsp_target_addr;
   logic [mwups_pkg::Q16_W-1:0]           rsp_expected_id;
   logic signed [mwups_pkg::Q16_W-1:0]    rsp_queue_len;
   logic [mwups_pkg::STATUS_W-1:0]        rsp_status;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [mwups_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [mwups_pkg::ADDR_W-1:0]          csr_data = '0;

   bit                           realtime_on;
   logic [31:0]                  weight_floor = 32'd1;
   logic [mwups_pkg::ADDR_W-1:0] client_addr_tbl [TABLE_DEPTH];
   logic [mwups_pkg::Q16_W-1:0]  client_rel_tbl [TABLE_DEPTH];
   int                           client_queue_tbl [TABLE_DEPTH];
   logic [mwups_pkg::Q16_W-1:0]  client_eid_tbl [TABLE_DEPTH];
   logic [mwups_pkg::Q16_W-1:0]  client_rcv_tbl [TABLE_DEPTH];
   int                           client_total;
   int                           poll_target;
   bit                           poll_target_set;

   poll_reply_type replies_due[$];
   int             mismatches;
   int             send_idle_pct;
   int             rsp_stall_pct;
   bit             timed_out;

   max_weight_uplink_poll_scheduler #(
      .MAX_CLIENTS(TABLE_DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_client_addr  (req_client_addr),
      .req_reliability  (req_reliability),
      .req_count        (req_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_target_valid (rsp_target_valid),
      .rsp_target_index (rsp_target_index),
      .rsp_target_addr  (rsp_target_addr),
      .rsp_expected_id  (rsp_expected_id),
      .rsp_queue_len    (rsp_queue_len),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [15:0] rand_q16();
      return 16'($urandom);
   endfunction

   function automatic int clamp_queue(int v);
      if (v > QUEUE_MAX) return QUEUE_MAX;
      if (v < QUEUE_MIN) return QUEUE_MIN;
      return v;
   endfunction

   function automatic poll_reply_type client_reply(int idx, logic sel,
                                                   logic [mwups_pkg::STATUS_W-1:0] st);
      poll_reply_type r;
      r.target_valid = sel;
      r.target_index = idx[mwups_pkg::INDEX_W-1:0];
      r.target_addr  = client_addr_tbl[idx];
      r.expected_id  = client_eid_tbl[idx];
      r.queue_len    = client_queue_tbl[idx][mwups_pkg::Q16_W-1:0];
      r.status       = st;
      return r;
   endfunction

   function automatic poll_reply_type apply_command(sched_cmd_type c);
      poll_reply_type r;
      int             cnt;
      int             rcv;
      int             best_i;
      longint         best_w;
      longint         w;
      longint         floor_w;
      r = '{default: '0};
      cnt = int'(c.count);
      case (c.kind)
         mwups_pkg::KIND_REGISTER: begin
            if (client_total >= TABLE_DEPTH) begin
               r.status = mwups_pkg::STATUS_FULL;
            end else begin
               client_addr_tbl[client_total]  = c.addr;
               client_rel_tbl[client_total]   = c.reliability;
               client_queue_tbl[client_total] = clamp_queue(cnt);
               client_eid_tbl[client_total]   = '0;
               client_rcv_tbl[client_total]   = '0;
               r = client_reply(client_total, 1'b0, mwups_pkg::STATUS_OK);
               client_total++;
            end
         end
         mwups_pkg::KIND_REPORT: begin
            if (!poll_target_set) begin
               r.status = mwups_pkg::STATUS_NO_TARGET;
            end else if (realtime_on && client_rcv_tbl[poll_target] != '0) begin
               r = client_reply(poll_target, 1'b0, mwups_pkg::STATUS_VIOLATION);
            end else begin
               rcv = int'(client_rcv_tbl[poll_target]);
               client_queue_tbl[poll_target] = clamp_queue(cnt - rcv);
               if (client_eid_tbl[poll_target] == '0 && client_queue_tbl[poll_target] > 0) begin
                  client_eid_tbl[poll_target] = 16'd1;
               end
               r = client_reply(poll_target, 1'b0, mwups_pkg::STATUS_OK);
            end
         end
         mwups_pkg::KIND_DATA: begin
            if (!poll_target_set) begin
               r.status = mwups_pkg::STATUS_NO_TARGET;
            end else begin
               client_queue_tbl[poll_target] = clamp_queue(client_queue_tbl[poll_target] - 1);
               client_eid_tbl[poll_target] = client_eid_tbl[poll_target] + 16'd1;
               client_rcv_tbl[poll_target] = client_rcv_tbl[poll_target] + 16'd1;
               r = client_reply(poll_target, 1'b0, mwups_pkg::STATUS_OK);
            end
         end
         mwups_pkg::KIND_POLL: begin
            if (client_total == 0) begin
               poll_target_set = 1'b0;
               r.status = mwups_pkg::STATUS_NO_TARGET;
            end else begin
               best_i = 0;
               best_w = longint'(client_queue_tbl[0]) * longint'(client_rel_tbl[0]);
               for (int i = 1; i < client_total; i++) begin
                  w = longint'(client_queue_tbl[i]) * longint'(client_rel_tbl[i]);
                  if (w > best_w) begin
                     best_w = w;
                     best_i = i;
                  end
               end
               floor_w = longint'(weight_floor);
               if (best_w < floor_w) begin
                  poll_target_set = 1'b0;
                  r.status = mwups_pkg::STATUS_NO_TARGET;
               end else begin
                  poll_target_set = 1'b1;
                  poll_target = best_i;
                  r = client_reply(best_i, 1'b1, mwups_pkg::STATUS_OK);
               end
            end
         end
         mwups_pkg::KIND_BEGIN: begin
            poll_target_set = 1'b0;
            if (realtime_on) begin
               for (int i = 0; i < client_total; i++) begin
                  client_rcv_tbl[i]   = '0;
                  client_eid_tbl[i]   = '0;
                  client_queue_tbl[i] = 0;
               end
            end
            r.status = mwups_pkg::STATUS_OK;
         end
         default: begin
            r.status = mwups_pkg::STATUS_OK;
         end
      endcase
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      poll_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            $display("%0t ns: reply beat with none expected, actual status %0h index %0h",
                     $time, rsp_status, rsp_target_index);
            mismatches++;
         end else begin
            want = replies_due.pop_front();
            check_field("target_valid", 32'(want.target_valid), 32'(rsp_target_valid));
            check_field("target_index", 32'(want.target_index), 32'(rsp_target_index));
            check_field("target_addr", want.target_addr, rsp_target_addr);
            check_field("expected_id", 32'(want.expected_id), 32'(rsp_expected_id));
            check_field("queue_len", 32'(want.queue_len), 32'(rsp_queue_len));
            check_field("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   task automatic send_item(sched_cmd_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= c.kind;
      req_client_addr <= c.addr;
      req_reliability <= c.reliability;
      req_count       <= c.count;
      do begin
         @(posedge clock);
      end while (!req_ready);
      replies_due.insert(replies_due.size(), apply_command(c));
   endtask

   task automatic send_cmd(logic [mwups_pkg::KIND_W-1:0] kind,
                           logic [mwups_pkg::ADDR_W-1:0] addr,
                           logic [mwups_pkg::Q16_W-1:0] rel,
                           logic [mwups_pkg::Q16_W-1:0] count);
      sched_cmd_type c;
      c.kind        = kind;
      c.addr        = addr;
      c.reliability = rel;
      c.count       = count;
      send_item(c);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(bit rt, logic [31:0] floor);
      logic [31:0] rt_word;
      rt_word    = $urandom;
      rt_word[0] = rt;
      csr_valid <= 1'b1;
      csr_index <= mwups_pkg::CSR_REALTIME;
      csr_data  <= rt_word;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      realtime_on = rt;
      csr_index <= mwups_pkg::CSR_MIN_WEIGHT;
      csr_data  <= floor;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      weight_floor = floor;
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   function automatic sched_cmd_type random_command();
      sched_cmd_type c;
      int            pick;
      int            shape;
      pick          = $urandom_range(99);
      c.addr        = $urandom;
      c.reliability = rand_q16();
      c.count       = rand_q16();
      if (pick < 8) begin
         c.kind = mwups_pkg::KIND_REGISTER;
         shape = $urandom_range(3);
         if (shape == 0) begin
            c.reliability = 16'hFFFF;
         end else if (shape == 1) begin
            c.reliability = '0;
         end
         if ($urandom_range(1) == 1) begin
            c.count = 16'($urandom_range(40));
         end
      end else if (pick < 40) begin
         c.kind = mwups_pkg::KIND_REPORT;
         if ($urandom_range(1) == 1) begin
            c.count = 16'($urandom_range(64));
         end
      end else if (pick < 72) begin
         c.kind = mwups_pkg::KIND_DATA;
      end else if (pick < 88) begin
         c.kind = mwups_pkg::KIND_POLL;
      end else if (pick < 95) begin
         c.kind = mwups_pkg::KIND_BEGIN;
      end else begin
         c.kind = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      end
      return c;
   endfunction

   task automatic run_traffic_phase(bit rt, logic [31:0] floor, int send_pct, int stall_pct,
                                    int beats);
      set_config(rt, floor);
      set_idling(send_pct, stall_pct);
      repeat (beats) send_item(random_command());
      drain_replies();
   endtask

   task automatic test_empty_table();
      set_idling(0, 0);
      send_cmd(mwups_pkg::KIND_POLL, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_DATA, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_BEGIN, $urandom, rand_q16(), rand_q16());
      for (int k = int'(KIND_UNUSED_LO); k <= int'(KIND_UNUSED_HI); k++) begin
         send_cmd(k[mwups_pkg::KIND_W-1:0], $urandom, rand_q16(), rand_q16());
      end
      drain_replies();
   endtask

   task automatic test_target_counters();
      int base;
      base = mismatches;
      set_config(1'b0, 32'd1);
      set_idling(0, 0);
      send_cmd(mwups_pkg::KIND_REGISTER, $urandom, 16'hFFFF, 16'd5);
      send_cmd(mwups_pkg::KIND_POLL, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), 16'd7);
      for (int n = 0; n < 24; n++) begin
         send_cmd(mwups_pkg::KIND_DATA, $urandom, rand_q16(), rand_q16());
         if (mismatches != base) break;
      end
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), 16'd0);
      drain_replies();
      set_config(1'b1, 32'd1);
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), rand_q16());
      for (int n = 0; n < 12; n++) begin
         send_cmd(mwups_pkg::KIND_DATA, $urandom, rand_q16(), rand_q16());
         if (mismatches != base) break;
      end
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), 16'hFFFF);
      send_cmd(mwups_pkg::KIND_BEGIN, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_DATA, $urandom, rand_q16(), rand_q16());
      drain_replies();
   endtask

   task automatic test_register_and_select();
      set_config(1'b0, 32'd1);
      set_idling(47, 0);
      send_cmd(mwups_pkg::KIND_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(mwups_pkg::KIND_REGISTER, 32'h0000_0000, 16'h0000, 16'h8000);
      send_cmd(mwups_pkg::KIND_REGISTER, $urandom, 16'hFFFF, 16'h7FFF);
      send_cmd(mwups_pkg::KIND_POLL, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_DATA, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_POLL, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), 16'd0);
      send_cmd(mwups_pkg::KIND_POLL, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), 16'h8000);
      drain_replies();
   endtask

   task automatic test_weight_threshold();
      set_idling(0, 47);
      set_config(1'b0, PEAK_WEIGHT);
      send_cmd(mwups_pkg::KIND_POLL, $urandom, rand_q16(), rand_q16());
      drain_replies();
      set_config(1'b0, PEAK_WEIGHT + 32'd1);
      send_cmd(mwups_pkg::KIND_POLL, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), rand_q16());
      drain_replies();
      set_config(1'b0, 32'hFFFF_FFFF);
      send_cmd(mwups_pkg::KIND_POLL, $urandom, rand_q16(), rand_q16());
      drain_replies();
      set_config(1'b1, 32'd0);
      send_cmd(mwups_pkg::KIND_POLL, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_BEGIN, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_POLL, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), 16'd3);
      send_cmd(mwups_pkg::KIND_DATA, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_REPORT, $urandom, rand_q16(), rand_q16());
      drain_replies();
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(1'b0, 32'd1, 0, 0, 90);
      run_traffic_phase(1'b1, 32'd0, 47, 0, 90);
      run_traffic_phase(1'b0, $urandom_range(4194304), 0, 47, 90);
      run_traffic_phase(1'b1, 32'd0, 38, 38, 90);
      run_traffic_phase(1'b0, 32'hFFFF_FFFF, 47, 47, 30);
      run_traffic_phase(1'b0, 32'd1, 38, 38, 90);
   endtask

   task automatic test_table_full();
      set_idling(38, 38);
      while (client_total < TABLE_DEPTH) begin
         send_cmd(mwups_pkg::KIND_REGISTER, $urandom, rand_q16(), rand_q16());
      end
      send_cmd(mwups_pkg::KIND_REGISTER, $urandom, rand_q16(), rand_q16());
      send_cmd(mwups_pkg::KIND_REGISTER, $urandom, rand_q16(), rand_q16());
      drain_replies();
   endtask

   task automatic watch_progress();
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      timed_out = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            test_empty_table();
            test_target_counters();
            test_register_and_select();
            test_weight_threshold();
            test_random_traffic();
            test_table_full();
         end
         watch_progress();
      join_any
      if (!timed_out && mismatches == 0 && replies_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/mwups_pkg.sv
rtl/mwups_ram.sv
rtl/mwups_argmax.sv
rtl/max_weight_uplink_poll_scheduler.sv
bench/tb_max_weight_uplink_poll_scheduler.sv
